// ===== src/pwag_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwag_pkg
// Shared types and constants of the panorama warp address generator.
// ----------------------------------------------------------------------------
package pwag_pkg;

	localparam int COL_W      = 10;
	localparam int ROW_W      = 10;
	localparam int STEP_W     = 22;
	localparam int START_W    = 31;
	localparam int SRC_W      = 12;
	localparam int PANO_W     = 13;
	localparam int PANX_W     = 14;
	localparam int PANY_W     = 16;
	localparam int PANYMAX_W  = 12;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int S_TDATA_W  = 80;
	localparam int M_TDATA_W  = 24;

	localparam int SCREEN_COLS_DEF = 1024;
	localparam int FRAC_BITS_DEF   = 22;

	localparam logic [PANO_W-1:0] PANO_RST = 13'd2048;
	localparam logic [PANO_W-1:0] H_MAX    = 13'd4096;
	localparam logic [PANX_W-1:0] BASE_RST = 14'd2047;
	localparam logic [SRC_W-1:0]  ROW_MAX  = 12'd4095;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_PIXEL = 1'b1;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam int DIV_STEPS = PANO_W;
	localparam int DCNT_W    = $clog2(DIV_STEPS);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PANO_COLUMNS,
		CFG_PAN_X,
		CFG_PAN_Y,
		CFG_PAN_Y_MAX
	} cfg_idx_t;

	typedef enum logic [1:0] {
		RED_IDLE,
		RED_LOAD,
		RED_DIV,
		RED_FIN
	} red_state_t;

	typedef enum logic [1:0] {
		RMODE_KEEP,
		RMODE_HIGH,
		RMODE_NEG
	} red_mode_t;

	typedef struct packed {
		logic               pixel;
		logic               inrange;
		logic [COL_W-1:0]   col;
		logic [ROW_W-1:0]   row;
		logic [STEP_W-1:0]  step;
		logic [START_W-1:0] start;
	} item_t;

	typedef struct packed {
		logic [PANO_W-1:0]    h;
		logic [PANX_W-1:0]    base;
		logic [PANYMAX_W-1:0] py;
	} warp_cfg_t;

endpackage

// ===== src/panorama_warp_address_gen.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// panorama_warp_address_gen
// Source address generator for a cylindrical panorama warp.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  tuser mode, tdata col/row/step/start
//   m_*      out  m_tvalid/m_tready  tdata source_col/source_row
//   cfg_*    in   cfg_we             cfg_index, cfg_wdata
//
// One item per cycle sustained while the queue has room and no config reload
// runs; a pixel item passes a four-entry queue and a five-stage execution
// pipeline. A config write reloads the pan reduction: a bit-serial remainder
// unit keeps s_tready low from the write cycle until the reduction finishes.
// Output stalls freeze the execution pipeline; the queue keeps taking input.
// Reset is asynchronous; tables are not cleared.
// ----------------------------------------------------------------------------
module panorama_warp_address_gen #(
	parameter int SCREEN_COLS = pwag_pkg::SCREEN_COLS_DEF,
	parameter int FRAC_BITS   = pwag_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pwag_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pwag_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic                            s_tuser,   // mode
	input  logic [pwag_pkg::S_TDATA_W-1:0]  s_tdata,   // screen_col, screen_row,
	                                                   // step_value, start_value
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [pwag_pkg::M_TDATA_W-1:0]  m_tdata    // source_col, source_row
);

	import pwag_pkg::*;

	logic      push, q_full, q_valid, q_pop;
	item_t     push_item, q_item;
	warp_cfg_t wcfg;

	pwag_front #(
		.SCREEN_COLS(SCREEN_COLS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.push     (push),
		.push_item(push_item),
		.wcfg     (wcfg)
	);

	pwag_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.q_full   (q_full),
		.q_pop    (q_pop),
		.q_valid  (q_valid),
		.q_item   (q_item)
	);

	pwag_back #(
		.SCREEN_COLS(SCREEN_COLS),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.wcfg    (wcfg),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	// no transfer while the pan reduction reloads
	a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !s_tready)
		else $error("input taken right after config write");

	// a transfer always lands in the queue
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> q_valid)
		else $error("transferred item missing from queue");

	// back drains the queue whenever the output is free
	a_back_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && !m_tvalid) |-> q_pop)
		else $error("queue not drained with output free");

endmodule

// ===== src/pwag_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwag_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module pwag_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/pwag_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwag_front
// Input side: config registers, pan reduction, input acceptance and
// classification of items into the queue.
// ----------------------------------------------------------------------------
module pwag_front #(
	parameter int SCREEN_COLS = pwag_pkg::SCREEN_COLS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pwag_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pwag_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic                                s_tuser,
	input  logic [pwag_pkg::S_TDATA_W-1:0]      s_tdata,
	input  logic                                q_full,
	output logic                                push,
	output pwag_pkg::item_t                     push_item,
	output pwag_pkg::warp_cfg_t                 wcfg
);

	import pwag_pkg::*;

	logic [PANO_W-1:0]        pano_q;
	logic signed [PANX_W-1:0] panx_q;
	logic signed [PANY_W-1:0] pany_q;
	logic [PANYMAX_W-1:0]     panymax_q;

	red_state_t               state_q, state_d;
	logic                     red_ld, red_div, red_fin;
	red_mode_t                rmode_q;
	logic [PANO_W-1:0]        d_q, rem_q, rem_next;
	logic [DCNT_W-1:0]        cnt_q;
	logic [PANO_W-1:0]        h_q, h_clamp;
	logic [PANX_W-1:0]        base_q, base_d;
	logic signed [PANX_W:0]   h15, p15, rem15, base15;
	logic [PANO_W:0]          trial;
	logic [PANYMAX_W-1:0]     py_clip;
	logic                     busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pano_q    <= PANO_RST;
			panx_q    <= '0;
			pany_q    <= '0;
			panymax_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_PANO_COLUMNS: pano_q    <= cfg_wdata[PANO_W-1:0];
				CFG_PAN_X:        panx_q    <= cfg_wdata[PANX_W-1:0];
				CFG_PAN_Y:        pany_q    <= cfg_wdata[PANY_W-1:0];
				CFG_PAN_Y_MAX:    panymax_q <= cfg_wdata[PANYMAX_W-1:0];
				default: ;
			endcase
		end
	end

	// circumference clamped to [1, 4096]
	always_comb begin
		if (pano_q == '0) begin
			h_clamp = PANO_W'(1);
		end else if (pano_q > H_MAX) begin
			h_clamp = H_MAX;
		end else begin
			h_clamp = pano_q;
		end
	end

	// pan reduction sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RED_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		red_ld  = 1'b0;
		red_div = 1'b0;
		red_fin = 1'b0;
		unique case (state_q)
			RED_IDLE: ;
			RED_LOAD: begin
				red_ld  = 1'b1;
				state_d = RED_DIV;
			end
			RED_DIV: begin
				red_div = 1'b1;
				if (cnt_q == '0) begin
					state_d = RED_FIN;
				end
			end
			RED_FIN: begin
				red_fin = 1'b1;
				state_d = RED_IDLE;
			end
			default: state_d = RED_IDLE;
		endcase
		if (cfg_we) begin
			state_d = RED_LOAD;
		end
	end

	assign p15 = {panx_q[PANX_W-1], panx_q};
	assign h15 = $signed({2'b00, h_q});
	assign rem15 = $signed({2'b00, rem_q});

	// restoring remainder, one bit per cycle
	always_comb begin
		trial = {rem_q, d_q[PANO_W-1]};
		if (trial >= {1'b0, h_q}) begin
			rem_next = PANO_W'(trial - {1'b0, h_q});
		end else begin
			rem_next = trial[PANO_W-1:0];
		end
	end

	always_comb begin
		unique case (rmode_q)
			RMODE_HIGH: base15 = h15 - 15'sd2 - rem15;
			RMODE_NEG:  base15 = rem15;
			default:    base15 = h15 - 15'sd1 - p15;
		endcase
		base_d = base15[PANX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (red_ld) begin
			rem_q <= '0;
			cnt_q <= DCNT_W'(DIV_STEPS - 1);
			if ($signed({panx_q[PANX_W-1], panx_q}) > $signed({2'b00, h_clamp})) begin
				rmode_q <= RMODE_HIGH;
				d_q     <= PANO_W'(panx_q - 14'sd1);
			end else if (panx_q[PANX_W-1]) begin
				rmode_q <= RMODE_NEG;
				d_q     <= ~panx_q[PANO_W-1:0];
			end else begin
				rmode_q <= RMODE_KEEP;
				d_q     <= panx_q[PANO_W-1:0];
			end
		end else if (red_div) begin
			rem_q <= rem_next;
			d_q   <= d_q << 1;
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q    <= PANO_RST;
			base_q <= BASE_RST;
		end else begin
			if (red_ld) begin
				h_q <= h_clamp;
			end
			if (red_fin) begin
				base_q <= base_d;
			end
		end
	end

	// vertical pan clipped to [0, pan_y_max]
	always_comb begin
		if (pany_q[PANY_W-1]) begin
			py_clip = '0;
		end else if (pany_q[PANY_W-2:0] > {3'b000, panymax_q}) begin
			py_clip = panymax_q;
		end else begin
			py_clip = pany_q[PANYMAX_W-1:0];
		end
	end

	assign wcfg.h    = h_q;
	assign wcfg.base = base_q;
	assign wcfg.py   = py_clip;

	assign busy     = (state_q != RED_IDLE) || cfg_we;
	assign s_tready = !q_full && !busy;
	assign push     = s_tvalid && s_tready;

	assign push_item.pixel   = (s_tuser == MODE_PIXEL);
	assign push_item.inrange = (32'(s_tdata[COL_W-1:0]) < SCREEN_COLS);
	assign push_item.col     = s_tdata[COL_W-1:0];
	assign push_item.row     = s_tdata[COL_W+ROW_W-1:COL_W];
	assign push_item.step    = s_tdata[COL_W+ROW_W+STEP_W-1:COL_W+ROW_W];
	assign push_item.start   = s_tdata[COL_W+ROW_W+STEP_W+START_W-1:COL_W+ROW_W+STEP_W];

endmodule

// ===== src/pwag_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwag_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module pwag_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pwag_pkg::item_t push_item,
	output logic            q_full,
	input  logic            q_pop,
	output logic            q_valid,
	output pwag_pkg::item_t q_item
);

	import pwag_pkg::*;

	item_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (q_pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	assign q_full  = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_item  = mem_q[rd_ptr_q];

endmodule

// ===== src/pwag_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwag_back
// Execution pipeline: table write/read, column modulo, row multiply-add,
// saturation and the output register.
// ----------------------------------------------------------------------------
module pwag_back #(
	parameter int SCREEN_COLS = pwag_pkg::SCREEN_COLS_DEF,
	parameter int FRAC_BITS   = pwag_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	input  pwag_pkg::item_t                q_item,
	output logic                           q_pop,
	input  pwag_pkg::warp_cfg_t            wcfg,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [pwag_pkg::M_TDATA_W-1:0] m_tdata
);

	import pwag_pkg::*;

	localparam int AW            = $clog2(SCREEN_COLS);
	localparam int ENTRY_W       = STEP_W + START_W;
	localparam int TV_W          = PANYMAX_W + 1;
	localparam int PROD_W        = TV_W + STEP_W;
	localparam int POS_W         = PROD_W + 1;
	localparam int MOD_PER_STAGE = 3;

	// up to three compare-subtract steps of col mod h per stage
	function automatic logic [COL_W-1:0] mod_stage(input logic [COL_W-1:0] rem_in,
			input logic [PANO_W-1:0] h, input int stage);
		logic [COL_W-1:0]        r;
		logic [COL_W+PANO_W-1:0] sh;
		int                      bitpos;
		r = rem_in;
		for (int j = 0; j < MOD_PER_STAGE; j++) begin
			bitpos = COL_W - 1 - MOD_PER_STAGE * stage - j;
			if (bitpos >= 0) begin
				sh = {{COL_W{1'b0}}, h} << bitpos;
				if ({{PANO_W{1'b0}}, r} >= sh) begin
					r = COL_W'({{PANO_W{1'b0}}, r} - sh);
				end
			end
		end
		return r;
	endfunction

	logic                 adv;
	logic                 v_s1, v_s2, v_s3, v_s4, v_s5;
	logic                 inrange_s1;
	logic [TV_W-1:0]      tv_s1;
	logic [COL_W-1:0]     rem_s1, rem_s2, rem_s3, rem_s4;
	logic [PROD_W-1:0]    prod_s2;
	logic [START_W-1:0]   start_s2;
	logic [POS_W-1:0]     pos_s3, row_full;
	logic [SRC_W-1:0]     srow_s4, srow_sat;
	logic [SRC_W-1:0]     scol_s5, srow_s5;
	logic [ENTRY_W-1:0]   rd_entry;
	logic [STEP_W-1:0]    step_m;
	logic [START_W-1:0]   start_m;
	logic                 ram_we, ram_re;
	logic [AW-1:0]        ram_addr;
	logic signed [PANX_W:0] sdiff, scol_fix;

	assign adv   = !v_s5 || m_tready;
	assign q_pop = adv && q_valid;

	assign ram_addr = AW'(q_item.col);
	assign ram_we   = q_pop && !q_item.pixel && q_item.inrange;
	assign ram_re   = q_pop && q_item.pixel && q_item.inrange;

	pwag_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SCREEN_COLS)
	) u_warp_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_addr),
		.wdata({q_item.step, q_item.start}),
		.re   (ram_re),
		.raddr(ram_addr),
		.rdata(rd_entry)
	);

	assign step_m  = inrange_s1 ? rd_entry[ENTRY_W-1:START_W] : '0;
	assign start_m = inrange_s1 ? rd_entry[START_W-1:0] : '0;

	assign row_full = pos_s3 >> FRAC_BITS;
	assign srow_sat = (row_full > POS_W'(ROW_MAX)) ? ROW_MAX : row_full[SRC_W-1:0];

	assign sdiff    = $signed({wcfg.base[PANX_W-1], wcfg.base}) - $signed({5'b00000, rem_s4});
	assign scol_fix = sdiff[PANX_W] ? (sdiff + $signed({2'b00, wcfg.h})) : sdiff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= q_pop && q_item.pixel;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			inrange_s1 <= q_item.inrange;
			tv_s1      <= {1'b0, wcfg.py} + TV_W'(q_item.row);
			rem_s1     <= mod_stage(q_item.col, wcfg.h, 0);

			prod_s2    <= PROD_W'(tv_s1) * PROD_W'(step_m);
			start_s2   <= start_m;
			rem_s2     <= mod_stage(rem_s1, wcfg.h, 1);

			pos_s3     <= {1'b0, prod_s2} + POS_W'(start_s2);
			rem_s3     <= mod_stage(rem_s2, wcfg.h, 2);

			srow_s4    <= srow_sat;
			rem_s4     <= mod_stage(rem_s3, wcfg.h, 3);

			scol_s5    <= scol_fix[SRC_W-1:0];
			srow_s5    <= srow_s4;
		end
	end

	assign m_tvalid = v_s5;
	assign m_tdata  = {srow_s5, scol_s5};

endmodule

// ===== tb/sv/panorama_warp_address_gen_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// panorama_warp_address_gen_test
// Self-checking testbench for the panorama warp address generator. Table
// writes and pixel requests are queued by the sequence and sent by a stream
// driver. A shadow copy of the tables and registers predicts every source
// address, and a monitor compares each result transfer field by field.
// Both sides idle at random, and the receiver stalls once for a long stretch.
// Registers change only between phases, while the block is idle.
// ----------------------------------------------------------------------------
module panorama_warp_address_gen_test;
	import pwag_pkg::*;

	localparam int DRAIN_CYCLES = 24;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 400;
	localparam int RAND_ITEMS   = 150;
	localparam int N_FIXED      = 6;
	localparam int N_RANDOM     = 3;

	typedef struct packed {
		logic               mode;
		logic [COL_W-1:0]   col;
		logic [ROW_W-1:0]   row;
		logic [STEP_W-1:0]  step;
		logic [START_W-1:0] start;
	} warp_req_t;

	typedef struct packed {
		logic [SRC_W-1:0] row;
		logic [SRC_W-1:0] col;
	} src_addr_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic                  s_tuser   = MODE_WRITE;
	logic [S_TDATA_W-1:0]  s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;

	// shadow registers and tables
	logic [PANO_W-1:0]           pano_reg    = PANO_RST;
	logic signed [PANX_W-1:0]    panx_reg    = '0;
	logic signed [PANY_W-1:0]    pany_reg    = '0;
	logic [PANYMAX_W-1:0]        panymax_reg = '0;
	logic [STEP_W-1:0]           step_mem  [SCREEN_COLS_DEF];
	logic [START_W-1:0]          start_mem [SCREEN_COLS_DEF];

	warp_req_t   req_q[$];
	src_addr_t   addr_expect_q[$];
	bit          col_written [SCREEN_COLS_DEF];
	int          written_cols[$];

	warp_req_t   tx_req;
	int          tx_gap = 0;
	int          rx_wait = 0;
	int          hold_cnt = 0;
	bit          hold_done = 1'b0;
	bit          no_idle = 1'b0;

	int          queued_total = 0;
	int          accepted_total = 0;
	int          pix_accepted = 0;
	int          writes_accepted = 0;
	int          results_seen = 0;
	int          fail_count = 0;
	int          phases_run = 0;

	panorama_warp_address_gen i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic src_addr_t warp_source(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
		int        h;
		int        p;
		int        s;
		int        py;
		int        c;
		int        rw;
		longint    st;
		longint    sp;
		longint    pos;
		src_addr_t r;
		h = int'(pano_reg);
		if (h < 1)
			h = 1;
		if (h > 4096)
			h = 4096;
		p = int'(panx_reg);
		if (p > h) begin
			p = ((p - 1) % h) + 1;
		end else if (p < 0) begin
			p = p % h;
			if (p < 0)
				p = p + h;
		end
		c = int'(col);
		rw = int'(row);
		s = (h - 1 - p - c) % h;
		if (s < 0)
			s = s + h;
		r.col = s[SRC_W-1:0];
		py = int'(pany_reg);
		if (py < 0)
			py = 0;
		if (py > int'(panymax_reg))
			py = int'(panymax_reg);
		st = longint'(start_mem[col]);
		sp = longint'(step_mem[col]);
		pos = (st + longint'(py + rw) * sp) >>> FRAC_BITS_DEF;
		if (pos > 4095)
			pos = 4095;
		r.row = pos[SRC_W-1:0];
		return r;
	endfunction

	// stream driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tuser  <= MODE_WRITE;
			s_tdata  <= '0;
			tx_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				accepted_total <= accepted_total + 1;
				if (s_tuser == MODE_WRITE) begin
					step_mem[s_tdata[9:0]]  = s_tdata[41:20];
					start_mem[s_tdata[9:0]] = s_tdata[72:42];
					writes_accepted <= writes_accepted + 1;
				end else begin
					addr_expect_q.push_back(warp_source(s_tdata[9:0], s_tdata[19:10]));
					pix_accepted <= pix_accepted + 1;
				end
			end
			if (!s_tvalid || s_tready) begin
				if (tx_gap != 0) begin
					tx_gap = tx_gap - 1;
					s_tvalid <= 1'b0;
				end else if (req_q.size() != 0) begin
					tx_req = req_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= tx_req.mode;
					s_tdata  <= {7'd0, tx_req.start, tx_req.step, tx_req.row, tx_req.col};
					tx_gap = (no_idle || hold_cnt != 0) ? 0 : $urandom_range(0, 17);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, once
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt  <= 0;
			hold_done <= 1'b0;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end else if (!hold_done && accepted_total >= HOLD_AT) begin
			hold_cnt  <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		src_addr_t exp_addr;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (addr_expect_q.size() == 0) begin
					fail_count = fail_count + 1;
					if (fail_count <= 10)
						$display("%0t: unexpected result col=%0d row=%0d", $realtime,
							m_tdata[11:0], m_tdata[23:12]);
				end else begin
					exp_addr = addr_expect_q.pop_front();
					results_seen <= results_seen + 1;
					if (m_tdata[11:0] !== exp_addr.col || m_tdata[23:12] !== exp_addr.row) begin
						fail_count = fail_count + 1;
						if (fail_count <= 10)
							$display("%0t: mismatch expected col=%0d row=%0d, got col=%0d row=%0d",
								$realtime, exp_addr.col, exp_addr.row,
								m_tdata[11:0], m_tdata[23:12]);
					end
				end
				rx_wait = no_idle ? 0 : $urandom_range(0, 17);
			end else if (rx_wait != 0 && hold_cnt == 0) begin
				rx_wait = rx_wait - 1;
			end
			m_tready <= (rx_wait == 0) && (hold_cnt == 0);
		end
	end

	task automatic push_write(int col, int step, int start);
		warp_req_t r;
		r.mode  = MODE_WRITE;
		r.col   = COL_W'(col);
		r.row   = ROW_W'($urandom());
		r.step  = STEP_W'(step);
		r.start = START_W'(start);
		req_q.push_back(r);
		queued_total++;
		if (!col_written[col]) begin
			col_written[col] = 1'b1;
			written_cols.push_back(col);
		end
	endtask

	task automatic push_pixel(int col, int row);
		warp_req_t r;
		r.mode  = MODE_PIXEL;
		r.col   = COL_W'(col);
		r.row   = ROW_W'(row);
		r.step  = STEP_W'($urandom());
		r.start = START_W'($urandom());
		req_q.push_back(r);
		queued_total++;
	endtask

	task automatic push_random(int n);
		repeat (n) begin
			if (written_cols.size() == 0 || $urandom_range(0, 99) < 30)
				push_write($urandom_range(0, 1023),
					$urandom_range(0, 4194303) >> $urandom_range(0, 21),
					($urandom() & 32'h7FFF_FFFF) >> $urandom_range(0, 30));
			else
				push_pixel(written_cols[$urandom_range(0, written_cols.size() - 1)],
					$urandom_range(0, 1023));
		end
	endtask

	// corner pixels that every setting should see
	task automatic push_corners();
		push_pixel(0, 0);
		push_pixel(0, 1023);
		push_pixel(1023, 0);
		push_pixel(1023, 1023);
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (accepted_total != queued_total || results_seen != pix_accepted);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, int val);
		logic [CFG_DATA_W-1:0] v;
		v = CFG_DATA_W'(val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			CFG_PANO_COLUMNS: pano_reg    = v[PANO_W-1:0];
			CFG_PAN_X:        panx_reg    = v[PANX_W-1:0];
			CFG_PAN_Y:        pany_reg    = v[PANY_W-1:0];
			CFG_PAN_Y_MAX:    panymax_reg = v[PANYMAX_W-1:0];
			default: ;
		endcase
	endtask

	task automatic run_phase(int h, int px, int py, int pmax);
		write_reg(CFG_PANO_COLUMNS, h);
		write_reg(CFG_PAN_X, px);
		write_reg(CFG_PAN_Y, py);
		write_reg(CFG_PAN_Y_MAX, pmax);
		phases_run++;
		no_idle <= (phases_run % 3 == 1);
		push_corners();
		push_random(RAND_ITEMS);
		wait_idle();
	endtask

	// circumference 1, 4096, 0, above 4096; pan at, above and below it;
	// pan_y below zero and above its limit; row saturation
	int set_h    [N_FIXED] = '{1, 4096, 0, 8191, 2048, 1000};
	int set_px   [N_FIXED] = '{0, 4096, -8192, 8191, 3000, 1000};
	int set_py   [N_FIXED] = '{-32768, 32767, 100, -1, 200, 32767};
	int set_pmax [N_FIXED] = '{4095, 4095, 50, 0, 300, 4095};

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, directed table extremes
		push_write(0, 0, 0);
		push_write(1023, 4194303, 32'h7FFF_FFFF);
		push_write(1, 4194303, 0);
		push_write(2, 0, 32'h7FFF_FFFF);
		push_write(512, 4194303, 5 << 22);
		push_write(3, 2097152, 32'h1555_5555);
		push_corners();
		push_pixel(1, 1023);
		push_pixel(2, 5);
		push_pixel(512, 100);
		push_pixel(3, 1023);
		push_write(0, 1234567, 32'h2AAA_AAAA);
		push_pixel(0, 512);
		push_pixel(1, 0);
		push_random(RAND_ITEMS);
		wait_idle();

		for (int i = 0; i < N_FIXED; i++)
			run_phase(set_h[i], set_px[i], set_py[i], set_pmax[i]);
		for (int i = 0; i < N_RANDOM; i++)
			run_phase($urandom_range(1, 4096), int'($urandom_range(0, 16383)) - 8192,
				int'($urandom_range(0, 65535)) - 32768, $urandom_range(0, 4095));

		if (addr_expect_q.size() != 0)
			fail_count = fail_count + 1;
		$display("Sent %0d table writes and %0d pixel requests over %0d register settings,",
			writes_accepted, pix_accepted, phases_run + 1);
		$display("checked %0d source addresses, %0d failures.", results_seen, fail_count);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Timeout waiting for results");
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== panorama_warp_address_gen.f =====
src/pwag_pkg.sv
src/pwag_ram.sv
src/pwag_front.sv
src/pwag_queue.sv
src/pwag_back.sv
src/panorama_warp_address_gen.sv
tb/sv/panorama_warp_address_gen_test.sv
